// ===== src/msi_pkg.sv =====
// shared types and constants for the multi-source safety interlock
`timescale 1ns / 1ps

package msi_pkg;

   localparam int OP_W   = 2;
   localparam int SRC_W  = 3;
   localparam int CNT_W  = 16;
   localparam int MASK_W = 8;

   localparam int NUM_SOURCES_DEFAULT = 8;

   localparam logic [CNT_W-1:0] DELAY_RESET = CNT_W'(500);
   localparam logic [CNT_W-1:0] SINCE_MAX   = {CNT_W{1'b1}};

   localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
   localparam logic [OP_W-1:0] OP_INITIATE = 2'd1;
   localparam logic [OP_W-1:0] OP_RECOVER  = 2'd2;

   // what one word asks of a single source lane
   typedef struct packed {
      logic             tick;
      logic             initiate;
      logic             recover;
      logic [CNT_W-1:0] delay;
   } lane_cmd_type;

   // what a source lane reports back to the lock logic
   typedef struct packed {
      logic active;
      logic active_tick;
      logic tick_clear;
      logic recover_clear;
      logic active_next;
   } lane_status_type;

endpackage

// ===== src/multi_source_safety_interlock.sv =====
// top level: input register, lock logic over all source lanes, result register
// a word accepted into the input register moves on to the result register once the result register can advance
// throughput: one word per cycle while the result register is not stalled; all lanes and the lock update in one pass
// req_stall rises only while the result register holds a word that is stalled
// reset (synchronous, active high) clears all sources, the lock and the button
// timer, and sets the release delay to 500 ticks
`timescale 1ns / 1ps

module multi_source_safety_interlock #(
   parameter int NUM_SOURCES = msi_pkg::NUM_SOURCES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [msi_pkg::OP_W-1:0]   req_operation,
   input  logic [msi_pkg::SRC_W-1:0]  req_source,
   input  logic                       req_button_pressed,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_locked,
   output logic                       rsp_lock_event,
   output logic                       rsp_unlock_event,
   output logic [msi_pkg::MASK_W-1:0] rsp_active_sources,
   input  logic                       csr_write_enable,
   input  logic [msi_pkg::CNT_W-1:0]  csr_write_data
);

   logic [msi_pkg::CNT_W-1:0] delay_ff;

   logic                      in_valid_ff, in_valid_in;
   logic [msi_pkg::OP_W-1:0]  op_ff;
   logic [msi_pkg::SRC_W-1:0] src_ff;
   logic                      pressed_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_locked_ff, rsp_lock_event_ff, rsp_unlock_event_ff;
   logic [msi_pkg::MASK_W-1:0] rsp_active_ff, rsp_active_in;

   logic                      lock_held_ff, lock_held_in;
   logic [msi_pkg::CNT_W-1:0] since_ff, since_in;

   logic advance, req_accept, commit;
   logic is_tick, button_recover;
   logic [msi_pkg::CNT_W-1:0] since_inc;

   msi_pkg::lane_cmd_type    lane_cmd    [NUM_SOURCES];
   msi_pkg::lane_status_type lane_status [NUM_SOURCES];

   logic [NUM_SOURCES-1:0] init_vec, active_vec, active_tick_vec;
   logic [NUM_SOURCES-1:0] tick_clear_vec, rec_clear_vec, active_next_vec;

   logic unlock_tick, lock_t, lock_ev, unlock_rec;

   // handshake
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign commit     = in_valid_ff && advance;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   // button timer, saturating
   assign is_tick   = (op_ff == msi_pkg::OP_TICK);
   assign since_inc = (since_ff == msi_pkg::SINCE_MAX) ? since_ff
                                                       : since_ff + msi_pkg::CNT_W'(1);
   assign since_in  = pressed_ff ? '0 : since_inc;

   // recovery from the button looks at the lock after this tick's countdowns
   assign button_recover = is_tick && !pressed_ff && lock_t && (since_inc > delay_ff);

   for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_lane
      logic src_hit;

      assign src_hit = (32'(src_ff) == g);

      assign lane_cmd[g].tick     = is_tick;
      assign lane_cmd[g].initiate = ((op_ff == msi_pkg::OP_INITIATE) && src_hit)
                                    || ((g == 0) && is_tick && pressed_ff);
      assign lane_cmd[g].recover  = ((op_ff == msi_pkg::OP_RECOVER) && src_hit)
                                    || ((g == 0) && button_recover);
      assign lane_cmd[g].delay    = delay_ff;

      msi_source_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .commit (commit),
         .cmd    (lane_cmd[g]),
         .status (lane_status[g])
      );

      assign init_vec[g]        = lane_cmd[g].initiate;
      assign active_vec[g]      = lane_status[g].active;
      assign active_tick_vec[g] = lane_status[g].active_tick;
      assign tick_clear_vec[g]  = lane_status[g].tick_clear;
      assign rec_clear_vec[g]   = lane_status[g].recover_clear;
      assign active_next_vec[g] = lane_status[g].active_next;
   end

   // global lock: countdown clears first, then initiate or recover
   always_comb begin
      unlock_tick  = lock_held_ff && (|tick_clear_vec) && !(|active_tick_vec);
      lock_t       = lock_held_ff && !unlock_tick;
      lock_ev      = (|init_vec) && !(|active_tick_vec) && !lock_t;
      unlock_rec   = lock_t && (|rec_clear_vec) && !(|active_next_vec);
      lock_held_in = (lock_t || ((|init_vec) && !(|active_tick_vec))) && !unlock_rec;
   end

   for (genvar b = 0; b < msi_pkg::MASK_W; b++) begin : g_mask
      if (b < NUM_SOURCES) begin : g_on
         assign rsp_active_in[b] = active_next_vec[b];
      end else begin : g_off
         assign rsp_active_in[b] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= msi_pkg::DELAY_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lock_held_ff <= 1'b0;
         since_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            delay_ff <= csr_write_data;
         end
         if (commit) begin
            lock_held_ff <= lock_held_in;
            if (is_tick) begin
               since_ff <= since_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= req_operation;
         src_ff     <= req_source;
         pressed_ff <= req_button_pressed;
      end
      if (commit) begin
         rsp_locked_ff       <= lock_held_in;
         rsp_lock_event_ff   <= lock_ev;
         rsp_unlock_event_ff <= unlock_tick || unlock_rec;
         rsp_active_ff       <= rsp_active_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_locked         = rsp_locked_ff;
   assign rsp_lock_event     = rsp_lock_event_ff;
   assign rsp_unlock_event   = rsp_unlock_event_ff;
   assign rsp_active_sources = rsp_active_ff;

`ifndef ASSERT_OFF
   // the lock is held exactly while some source is active
   a_lock_matches_sources: assert property (@(posedge clock) disable iff (reset)
      lock_held_ff == (|active_vec))
      else $error("lock state disagrees with active sources");

   // a word that asserted the lock leaves it held
   a_lock_event_locked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_lock_event_ff) |-> rsp_locked_ff)
      else $error("lock event reported with lock released");

   // a release with no re-lock leaves the lock down
   a_unlock_event_released: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_unlock_event_ff && !rsp_lock_event_ff) |-> !rsp_locked_ff)
      else $error("unlock event reported with lock held");

   // lock and button timer move only when a word is committed
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !commit |=> ($stable(lock_held_ff) && $stable(since_ff)))
      else $error("interlock state changed without a word");
`endif

endmodule

// ===== src/msi_source_lane.sv =====
// one lock source: active flag, release flag and release countdown
`timescale 1ns / 1ps

module msi_source_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    commit,
   input  msi_pkg::lane_cmd_type   cmd,
   output msi_pkg::lane_status_type status
);

   logic                      active_ff, active_in;
   logic                      releasing_ff, releasing_in;
   logic [msi_pkg::CNT_W-1:0] count_ff, count_in;

   logic                      dec;
   logic [msi_pkg::CNT_W-1:0] count_dec;
   logic                      tick_clear;
   logic                      active_t, releasing_t;
   logic [msi_pkg::CNT_W-1:0] count_t;
   logic                      recover_clear;

   always_comb begin
      dec        = cmd.tick && releasing_ff && (count_ff != '0);
      count_dec  = count_ff - msi_pkg::CNT_W'(1);
      tick_clear = dec && (count_dec == '0);

      // state after the tick countdown, before any initiate or recover
      active_t    = tick_clear ? 1'b0 : active_ff;
      releasing_t = tick_clear ? 1'b0 : releasing_ff;
      count_t     = tick_clear ? '0 : (dec ? count_dec : count_ff);

      active_in     = active_t;
      releasing_in  = releasing_t;
      count_in      = count_t;
      recover_clear = 1'b0;

      priority if (cmd.initiate) begin
         active_in    = 1'b1;
         releasing_in = 1'b0;
         count_in     = '0;
      end else if (cmd.recover && active_t && !releasing_t) begin
         if (cmd.delay == '0) begin
            active_in     = 1'b0;
            releasing_in  = 1'b0;
            count_in      = '0;
            recover_clear = 1'b1;
         end else begin
            releasing_in = 1'b1;
            count_in     = cmd.delay;
         end
      end else begin
         recover_clear = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         releasing_ff <= 1'b0;
         count_ff     <= '0;
      end else if (commit) begin
         active_ff    <= active_in;
         releasing_ff <= releasing_in;
         count_ff     <= count_in;
      end
   end

   assign status.active        = active_ff;
   assign status.active_tick   = active_t;
   assign status.tick_clear    = tick_clear;
   assign status.recover_clear = recover_clear;
   assign status.active_next   = active_in;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the multi-source safety interlock
`timescale 1ns / 1ps

module testbench;

   localparam int NSRC = msi_pkg::NUM_SOURCES_DEFAULT;
   localparam logic [msi_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [msi_pkg::OP_W-1:0]  op;
      logic [msi_pkg::SRC_W-1:0] src;
      logic                      pressed;
   } lock_cmd_type;

   typedef struct packed {
      logic                       locked;
      logic                       lock_ev;
      logic                       unlock_ev;
      logic [msi_pkg::MASK_W-1:0] holders;
   } lock_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [msi_pkg::OP_W-1:0]   req_operation = msi_pkg::OP_TICK;
   logic [msi_pkg::SRC_W-1:0]  req_source = '0;
   logic                       req_button_pressed = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_locked;
   logic                       rsp_lock_event;
   logic                       rsp_unlock_event;
   logic [msi_pkg::MASK_W-1:0] rsp_active_sources;
   logic                       csr_write_enable = 1'b0;
   logic [msi_pkg::CNT_W-1:0]  csr_write_data = '0;

   multi_source_safety_interlock u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_source         (req_source),
      .req_button_pressed (req_button_pressed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_locked         (rsp_locked),
      .rsp_lock_event     (rsp_lock_event),
      .rsp_unlock_event   (rsp_unlock_event),
      .rsp_active_sources (rsp_active_sources),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   lock_cmd_type    cmd_q[$];
   lock_status_type predicted_status_q[$];
   lock_cmd_type    cur_cmd;
   lock_status_type want;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              mismatch_count = 0;

   // interlock state as the testbench sees it
   logic                      src_holding [NSRC];
   logic                      src_draining [NSRC];
   logic [msi_pkg::CNT_W-1:0] drain_left [NSRC];
   logic                      lock_on;
   logic [msi_pkg::CNT_W-1:0] button_idle_ticks;
   logic [msi_pkg::CNT_W-1:0] unlock_delay;
   logic                      saw_lock;
   logic                      saw_unlock;

   function automatic logic any_holding();
      for (int i = 0; i < NSRC; i++) begin
         if (src_holding[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void clear_src(int s);
      src_holding[s]  = 1'b0;
      src_draining[s] = 1'b0;
      drain_left[s]   = '0;
      if (lock_on && !any_holding()) begin
         lock_on    = 1'b0;
         saw_unlock = 1'b1;
      end
   endfunction

   function automatic void initiate_src(int s);
      if (!any_holding()) begin
         if (!lock_on) saw_lock = 1'b1;
         lock_on = 1'b1;
      end
      src_draining[s] = 1'b0;
      drain_left[s]   = '0;
      src_holding[s]  = 1'b1;
   endfunction

   function automatic void recover_src(int s);
      if (!src_holding[s] || src_draining[s]) return;
      if (unlock_delay == '0) begin
         clear_src(s);
         return;
      end
      src_draining[s] = 1'b1;
      drain_left[s]   = unlock_delay;
   endfunction

   function automatic void tick_all(logic pressed);
      for (int i = 0; i < NSRC; i++) begin
         if (src_draining[i] && drain_left[i] != '0) begin
            drain_left[i] = drain_left[i] - 1'b1;
            if (drain_left[i] == '0) clear_src(i);
         end
      end
      if (pressed) begin
         initiate_src(0);
         button_idle_ticks = '0;
      end else begin
         if (button_idle_ticks != msi_pkg::SINCE_MAX) begin
            button_idle_ticks = button_idle_ticks + 1'b1;
         end
         if (lock_on && button_idle_ticks > unlock_delay) recover_src(0);
      end
   endfunction

   function automatic lock_status_type predict_interlock(logic [msi_pkg::OP_W-1:0] op,
                                                         logic [msi_pkg::SRC_W-1:0] src,
                                                         logic pressed);
      lock_status_type st;
      saw_lock   = 1'b0;
      saw_unlock = 1'b0;
      case (op)
         msi_pkg::OP_TICK:     tick_all(pressed);
         msi_pkg::OP_INITIATE: initiate_src(int'(src));
         msi_pkg::OP_RECOVER:  recover_src(int'(src));
         default:              ;
      endcase
      st.locked    = lock_on;
      st.lock_ev   = saw_lock;
      st.unlock_ev = saw_unlock;
      for (int i = 0; i < msi_pkg::MASK_W; i++) begin
         st.holders[i] = (i < NSRC) ? src_holding[i] : 1'b0;
      end
      return st;
   endfunction

   // driver: one word in the slot, refilled from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_status_q.push_back(
               predict_interlock(req_operation, req_source, req_button_pressed));
         end
         if (!req_valid || !req_stall) begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_cmd = cmd_q.pop_front();
               req_valid          <= 1'b1;
               req_operation      <= cur_cmd.op;
               req_source         <= cur_cmd.src;
               req_button_pressed <= cur_cmd.pressed;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // monitor: compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_status_q.size() == 0) begin
               $display("%0t: unexpected result word locked %0b active %0h", $time,
                        rsp_locked, rsp_active_sources);
               mismatch_count++;
            end else begin
               want = predicted_status_q.pop_front();
               check_field("locked", want.locked, rsp_locked);
               check_field("lock_event", want.lock_ev, rsp_lock_event);
               check_field("unlock_event", want.unlock_ev, rsp_unlock_event);
               check_field("active_sources", want.holders, rsp_active_sources);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic push_cmd(logic [msi_pkg::OP_W-1:0] op, logic [msi_pkg::SRC_W-1:0] src,
                           logic pressed);
      lock_cmd_type c;
      c.op      = op;
      c.src     = src;
      c.pressed = pressed;
      cmd_q.push_back(c);
   endtask

   // half ticks and mostly low sources so that releases complete and the lock drops
   task automatic push_random(int n);
      int r;
      lock_cmd_type c;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 50) c.op = msi_pkg::OP_TICK;
         else if (r < 70) c.op = msi_pkg::OP_INITIATE;
         else if (r < 95) c.op = msi_pkg::OP_RECOVER;
         else c.op = OP_UNUSED;
         c.src = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(0, 2));
         if (c.op == msi_pkg::OP_TICK) c.pressed = ($urandom_range(0, 99) < 15);
         else c.pressed = 1'($urandom_range(0, 1));
         cmd_q.push_back(c);
      end
   endtask

   task automatic wait_idle();
      while (cmd_q.size() != 0 || req_valid || predicted_status_q.size() != 0)
         @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_delay(logic [msi_pkg::CNT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      unlock_delay = value;
      @(negedge clock);
   endtask

   task automatic run_random(logic [msi_pkg::CNT_W-1:0] value, int snd, int rcv, int n);
      wait_idle();
      write_delay(value);
      send_idle_pct = snd;
      recv_idle_pct = rcv;
      push_random(n);
   endtask

   initial begin
      for (int i = 0; i < NSRC; i++) begin
         src_holding[i]  = 1'b0;
         src_draining[i] = 1'b0;
         drain_left[i]   = '0;
      end
      lock_on           = 1'b0;
      button_idle_ticks = '0;
      unlock_delay      = msi_pkg::DELAY_RESET;
      send_idle_pct     = 31;
      recv_idle_pct     = 61;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset delay: lock, start a release and abort it
      push_cmd(msi_pkg::OP_TICK, 3'd0, 1'b0);
      push_cmd(msi_pkg::OP_INITIATE, 3'd7, 1'b0);
      push_cmd(msi_pkg::OP_RECOVER, 3'd7, 1'b1);
      push_cmd(msi_pkg::OP_INITIATE, 3'd7, 1'b1);

      wait_idle();
      write_delay(16'd2);
      push_cmd(msi_pkg::OP_INITIATE, 3'd0, 1'b0);
      push_cmd(msi_pkg::OP_RECOVER, 3'd7, 1'b0);
      push_cmd(msi_pkg::OP_RECOVER, 3'd7, 1'b0);   // already releasing
      push_cmd(msi_pkg::OP_RECOVER, 3'd4, 1'b0);   // inactive source
      push_cmd(OP_UNUSED, 3'd5, 1'b1);
      repeat (2) push_cmd(msi_pkg::OP_TICK, 3'd0, 1'b0);
      // button timer passes the delay, source 0 drains and the lock drops
      repeat (3) push_cmd(msi_pkg::OP_TICK, 3'd0, 1'b0);
      push_cmd(msi_pkg::OP_TICK, 3'd0, 1'b1);
      repeat (4) push_cmd(msi_pkg::OP_TICK, 3'd0, 1'b0);
      // release and re-lock by the button in one tick
      push_cmd(msi_pkg::OP_TICK, 3'd7, 1'b1);

      wait_idle();
      write_delay(16'd0);
      push_cmd(msi_pkg::OP_INITIATE, 3'd7, 1'b0);
      push_cmd(msi_pkg::OP_RECOVER, 3'd0, 1'b0);
      push_cmd(msi_pkg::OP_RECOVER, 3'd7, 1'b1);

      run_random(16'd1, 31, 61, 75);
      run_random(16'd0, 31, 61, 75);
      run_random(16'hFFFF, 61, 31, 75);
      run_random(16'd4, 61, 31, 75);
      run_random(16'($urandom_range(2, 30)), 0, 0, 75);
      run_random(16'd3, 0, 0, 75);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
src/msi_pkg.sv
src/msi_source_lane.sv
src/multi_source_safety_interlock.sv
tb/testbench.sv
